// ===== hw/rtl/gwf_pkg.sv =====
// Shared types and constants for the grid ray wall finder.
package gwf_pkg;

  localparam int GridBitsDef  = 6;
  localparam int TileTypesDef = 16;

  localparam int CoordW  = 6;
  localparam int TypeW   = 4;
  localparam int PosW    = 16;
  localparam int DirW    = 16;
  localparam int FracW   = 10;
  localparam int MaskW   = 16;
  localparam int MaxDW   = 7;
  localparam int DistW   = 32;
  localparam int NumW    = 31;
  localparam int MagW    = 16;
  localparam int InTdW   = 88;
  localparam int OutTdW  = 24;

  localparam logic [DistW-1:0] InfDist = '1;

  typedef enum logic [0:0] {
    CfgWalkableMask = 1'b0,
    CfgMaxDistance  = 1'b1
  } cfg_idx_e;

  typedef enum logic [0:0] {
    FuncWrite = 1'b0,
    FuncCast  = 1'b1
  } func_e;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StDivStart,
    StDiv,
    StRead,
    StEval,
    StDone
  } state_e;

endpackage

// ===== hw/rtl/grid_ray_wall_finder.sv =====
// Ray caster over a square tile map: DDA walk with map and drawn-mark memories.
// A write item updates the map when it is accepted. A cast whose start cell is on the grid
// runs 4 divisions on one shared bit-serial divider (a division is skipped when its direction
// component is zero), then a map read and an evaluate step per visited cell, then hands over
// the result, waiting while the previous result is still held. A cast with new_frame first
// sweeps all 2^(2*GRID_BITS) mark cells; after reset the same sweep runs before items enter.
module grid_ray_wall_finder
  import gwf_pkg::*;
#(
  parameter int GRID_BITS  = GridBitsDef,
  parameter int TILE_TYPES = TileTypesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_idx_i,
  input  logic [MaskW-1:0]  cfg_data_i,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  // tile_x[5:0] tile_y[11:6] tile_type[15:12] pos_x[31:16] pos_y[47:32]
  // dir_x[63:48] dir_y[79:64] new_frame[80], zeros above
  input  logic [InTdW-1:0]  s_axis_tdata,
  // func[0]
  input  logic              s_axis_tuser,
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  // hit[0] hit_x[6:1] hit_y[12:7] hit_type[16:13] first_in_frame[17], zeros above
  output logic [OutTdW-1:0] m_axis_tdata
);

  localparam int XW    = (GRID_BITS > CoordW) ? GRID_BITS : CoordW;
  localparam int AW    = 2 * GRID_BITS;
  localparam int Cells = 1 << AW;

  logic [TypeW-1:0] map_mem [Cells];
  logic             mark_mem [Cells];

  state_e           state_q, state_d;
  logic [MaskW-1:0] wmask_q;
  logic [MaxDW-1:0] maxd_q;
  logic [AW-1:0]    clr_cnt_q;
  logic             clr_then_cast_q;

  logic [XW-1:0]    cx_q, cy_q;
  logic [FracW:0]   frac_x_q, frac_y_q;
  logic [MagW-1:0]  mag_x_q, mag_y_q;
  logic             sx_neg_q, sy_neg_q;
  logic [DistW-1:0] side_x_q, side_y_q, dx_q, dy_q;
  logic [1:0]       op_q;
  logic [4:0]       div_cnt_q;
  logic [NumW-1:0]  num_q, quo_q;
  logic [MagW:0]    rem_q;
  logic [MagW-1:0]  dmag_q;
  logic             hit_q, first_q;
  logic [TypeW-1:0] type_q;
  logic [TypeW-1:0] map_rd_q;
  logic             mark_rd_q;

  logic             out_valid_q;
  logic [OutTdW-1:0] out_data_q;

  // input fields
  logic [CoordW-1:0] in_tx, in_ty;
  logic [TypeW-1:0]  in_tt;
  logic [PosW-1:0]   in_px, in_py;
  logic [DirW-1:0]   in_dx, in_dy;
  logic              in_nf;
  assign in_tx = s_axis_tdata[5:0];
  assign in_ty = s_axis_tdata[11:6];
  assign in_tt = s_axis_tdata[15:12];
  assign in_px = s_axis_tdata[31:16];
  assign in_py = s_axis_tdata[47:32];
  assign in_dx = s_axis_tdata[63:48];
  assign in_dy = s_axis_tdata[79:64];
  assign in_nf = s_axis_tdata[80];

  assign s_axis_tready = (state_q == StIdle);
  logic in_fire;
  assign in_fire = s_axis_tvalid && s_axis_tready;

  logic [XW-1:0] wr_tx, wr_ty, st_cx, st_cy;
  assign wr_tx = XW'(in_tx);
  assign wr_ty = XW'(in_ty);
  assign st_cx = XW'(in_px[PosW-1:FracW]);
  assign st_cy = XW'(in_py[PosW-1:FracW]);

  logic map_we;
  logic [AW-1:0] map_wa;
  assign map_we = in_fire && (s_axis_tuser == FuncWrite) &&
                  ((wr_tx >> GRID_BITS) == '0) && ((wr_ty >> GRID_BITS) == '0) &&
                  ({1'b0, in_tt} < (TypeW + 1)'(TILE_TYPES));
  assign map_wa = {wr_ty[GRID_BITS-1:0], wr_tx[GRID_BITS-1:0]};

  logic [AW-1:0] cur_idx;
  assign cur_idx = {cy_q[GRID_BITS-1:0], cx_q[GRID_BITS-1:0]};

  // start cell of the held cast lies off the grid
  logic start_out;
  assign start_out = ((cx_q >> GRID_BITS) != '0) || ((cy_q >> GRID_BITS) != '0);

  // step decision
  logic [DistW-1:0] limit;
  assign limit = DistW'({maxd_q, 16'b0});
  logic blocked, step_x, side_sel_over, x_edge, y_edge;
  assign blocked = !wmask_q[map_rd_q];
  assign step_x  = side_x_q < side_y_q;
  assign side_sel_over = step_x ? (side_x_q >= limit) : (side_y_q >= limit);
  assign x_edge = sx_neg_q ? (cx_q == '0) : (cx_q == XW'((1 << GRID_BITS) - 1));
  assign y_edge = sy_neg_q ? (cy_q == '0) : (cy_q == XW'((1 << GRID_BITS) - 1));

  // divider step
  logic [MagW:0]   rem_sh;
  logic            q_bit;
  assign rem_sh = {rem_q[MagW-1:0], num_q[NumW-1]};
  assign q_bit  = rem_sh >= {1'b0, dmag_q};

  logic [NumW-1:0] div_num;
  logic [MagW-1:0] div_mag;
  always_comb begin
    case (op_q)
      2'd0:    begin div_num = {frac_x_q, 20'b0};   div_mag = mag_x_q; end
      2'd1:    begin div_num = NumW'(1 << 30);      div_mag = mag_x_q; end
      2'd2:    begin div_num = {frac_y_q, 20'b0};   div_mag = mag_y_q; end
      default: begin div_num = NumW'(1 << 30);      div_mag = mag_y_q; end
    endcase
  end

  logic mark_we, mark_wd;
  logic [AW-1:0] mark_wa;
  always_comb begin
    mark_we = 1'b0;
    mark_wd = 1'b0;
    mark_wa = clr_cnt_q;
    if (state_q == StClear) begin
      mark_we = 1'b1;
    end else if (state_q == StEval && blocked && !mark_rd_q) begin
      mark_we = 1'b1;
      mark_wd = 1'b1;
      mark_wa = cur_idx;
    end
  end

  always_ff @(posedge clk_i) begin
    if (map_we) map_mem[map_wa] <= in_tt;
    if (mark_we) mark_mem[mark_wa] <= mark_wd;
    map_rd_q  <= map_mem[cur_idx];
    mark_rd_q <= mark_mem[cur_idx];
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      StClear: begin
        if (clr_cnt_q == '1)
          state_d = clr_then_cast_q ? (start_out ? StDone : StDivStart) : StIdle;
      end
      StIdle: begin
        if (in_fire && s_axis_tuser == FuncCast) begin
          if (in_nf) state_d = StClear;
          else if ((st_cx >> GRID_BITS) != '0 || (st_cy >> GRID_BITS) != '0)
            state_d = StDone;
          else state_d = StDivStart;
        end
      end
      StDivStart: state_d = (div_mag == '0) ? ((op_q == 2'd3) ? StRead : StDivStart) : StDiv;
      StDiv:      if (div_cnt_q == 5'd30) state_d = (op_q == 2'd3) ? StRead : StDivStart;
      StRead:     state_d = StEval;
      StEval: begin
        if (blocked || side_sel_over) state_d = StDone;
        else if (step_x ? x_edge : y_edge) state_d = StDone;
        else state_d = StRead;
      end
      StDone:     if (!out_valid_q || m_axis_tready) state_d = StIdle;
      default:    state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= StClear;
      clr_cnt_q       <= '0;
      clr_then_cast_q <= 1'b0;
      wmask_q         <= MaskW'(1);
      maxd_q          <= MaxDW'(16);
      out_valid_q     <= 1'b0;
      op_q            <= 2'd0;
      div_cnt_q       <= '0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CfgWalkableMask: wmask_q <= cfg_data_i;
          CfgMaxDistance:  maxd_q  <= cfg_data_i[MaxDW-1:0];
          default: ;
        endcase
      end
      if (state_q == StClear) clr_cnt_q <= clr_cnt_q + 1'b1;
      if (state_q == StIdle && in_fire) begin
        clr_then_cast_q <= 1'b1;
        op_q <= 2'd0;
      end
      if (state_q == StDivStart) begin
        div_cnt_q <= '0;
        if (div_mag == '0) op_q <= op_q + 1'b1;
      end
      if (state_q == StDiv) begin
        div_cnt_q <= div_cnt_q + 1'b1;
        if (div_cnt_q == 5'd30) op_q <= op_q + 1'b1;
      end
      if (m_axis_tready) out_valid_q <= 1'b0;
      if (state_q == StDone && (!out_valid_q || m_axis_tready)) out_valid_q <= 1'b1;
    end
  end

  logic [NumW-1:0] quo_next;
  assign quo_next = {quo_q[NumW-2:0], q_bit};

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_fire) begin
      cx_q     <= st_cx;
      cy_q     <= st_cy;
      sx_neg_q <= in_dx[DirW-1];
      sy_neg_q <= in_dy[DirW-1];
      mag_x_q  <= in_dx[DirW-1] ? MagW'(-in_dx) : in_dx;
      mag_y_q  <= in_dy[DirW-1] ? MagW'(-in_dy) : in_dy;
      frac_x_q <= in_dx[DirW-1] ? {1'b0, in_px[FracW-1:0]}
                                : (FracW + 1)'(1024) - {1'b0, in_px[FracW-1:0]};
      frac_y_q <= in_dy[DirW-1] ? {1'b0, in_py[FracW-1:0]}
                                : (FracW + 1)'(1024) - {1'b0, in_py[FracW-1:0]};
      hit_q    <= 1'b0;
      first_q  <= 1'b0;
      type_q   <= '0;
    end
    if (state_q == StDivStart) begin
      num_q  <= div_num;
      dmag_q <= div_mag;
      rem_q  <= '0;
      quo_q  <= '0;
      if (div_mag == '0) begin
        unique case (op_q)
          2'd0:    side_x_q <= InfDist;
          2'd1:    dx_q     <= InfDist;
          2'd2:    side_y_q <= InfDist;
          default: dy_q     <= InfDist;
        endcase
      end
    end
    if (state_q == StDiv) begin
      num_q <= {num_q[NumW-2:0], 1'b0};
      rem_q <= q_bit ? rem_sh - {1'b0, dmag_q} : rem_sh;
      quo_q <= quo_next;
      if (div_cnt_q == 5'd30) begin
        unique case (op_q)
          2'd0:    side_x_q <= DistW'(quo_next);
          2'd1:    dx_q     <= DistW'(quo_next);
          2'd2:    side_y_q <= DistW'(quo_next);
          default: dy_q     <= DistW'(quo_next);
        endcase
      end
    end
    if (state_q == StEval) begin
      if (blocked) begin
        hit_q   <= 1'b1;
        type_q  <= map_rd_q;
        first_q <= !mark_rd_q;
      end else if (!side_sel_over) begin
        if (step_x) begin
          side_x_q <= side_x_q + dx_q;
          if (!x_edge) cx_q <= sx_neg_q ? cx_q - 1'b1 : cx_q + 1'b1;
        end else begin
          side_y_q <= side_y_q + dy_q;
          if (!y_edge) cy_q <= sy_neg_q ? cy_q - 1'b1 : cy_q + 1'b1;
        end
      end
    end
    if (state_q == StDone && (!out_valid_q || m_axis_tready)) begin
      out_data_q <= {6'b0, first_q, type_q, cy_q[CoordW-1:0], cx_q[CoordW-1:0], hit_q};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== verif/tb_grid_ray_wall_finder.sv =====
// Self-checking testbench for grid_ray_wall_finder: map writes and DDA ray casts.
module tb_grid_ray_wall_finder;
  import gwf_pkg::*;

  localparam int NCells   = 4096;
  localparam int FenceAt  = 16;
  localparam int WdLimit  = 40000;
  localparam longint unsigned FarAway = 64'hFFFF_FFFF_FFFF_FFFF;

  typedef struct {
    func_e       func;
    logic [5:0]  tile_x;
    logic [5:0]  tile_y;
    logic [3:0]  tile_type;
    logic [15:0] pos_x;
    logic [15:0] pos_y;
    logic [15:0] dir_x;
    logic [15:0] dir_y;
    logic        new_frame;
  } ray_item_t;

  typedef struct {
    logic       hit;
    logic [5:0] hit_x;
    logic [5:0] hit_y;
    logic [3:0] hit_type;
    logic       first;
  } wall_hit_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_idx_i = 1'b0;
  logic [MaskW-1:0]  cfg_data_i = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [InTdW-1:0]  s_axis_tdata = '0;
  logic              s_axis_tuser = 1'b0;
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [OutTdW-1:0] m_axis_tdata;

  grid_ray_wall_finder i_dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // predictor state
  logic [3:0]      tiles [NCells];
  bit              marks [NCells];
  logic [15:0]     walk_mask = 16'd1;
  logic [6:0]      dist_cap = 7'd16;
  wall_hit_t       pending_hits[$];
  int              errors = 0;
  int              casts_sent = 0;
  int              writes_sent = 0;
  int              hits_seen = 0;
  int              results_seen = 0;
  bit              no_idle = 1'b0;
  int              idle_cycles = 0;

  function automatic void axis_prep(input logic [15:0] pos, input logic [15:0] dir,
                                    output longint unsigned side,
                                    output longint unsigned delta, output int step);
    longint unsigned mag;
    longint unsigned frac;
    mag = dir[15] ? (64'h10000 - dir) : dir;
    frac = pos[9:0];
    if (mag == 0) begin
      side = FarAway;
      delta = FarAway;
      step = 0;
    end else begin
      if (dir[15]) begin
        step = -1;
      end else begin
        step = 1;
        frac = 1024 - frac;
      end
      side = (frac << 20) / mag;
      delta = (64'd1 << 30) / mag;
    end
  endfunction

  function automatic void trace_ray(input ray_item_t it, output wall_hit_t r);
    longint unsigned sx_d, sy_d, dx_d, dy_d, lim;
    int stx, sty, cx, cy, nx, ny, idx;
    logic [3:0] t;
    r = '{hit: 1'b0, hit_x: '0, hit_y: '0, hit_type: '0, first: 1'b0};
    if (it.new_frame) marks = '{default: 1'b0};
    cx = it.pos_x[15:10];
    cy = it.pos_y[15:10];
    axis_prep(it.pos_x, it.dir_x, sx_d, dx_d, stx);
    axis_prep(it.pos_y, it.dir_y, sy_d, dy_d, sty);
    lim = longint'(dist_cap) << 16;
    forever begin
      idx = cy * 64 + cx;
      t = tiles[idx];
      nx = cx;
      ny = cy;
      if (!walk_mask[t]) begin
        r.hit = 1'b1;
        r.hit_type = t;
        if (!marks[idx]) begin
          r.first = 1'b1;
          marks[idx] = 1'b1;
        end
        break;
      end
      if (sx_d < sy_d) begin
        if (sx_d >= lim) break;
        sx_d += dx_d;
        nx += stx;
      end else begin
        if (sy_d >= lim) break;
        if (sy_d != FarAway) sy_d += dy_d;
        ny += sty;
      end
      if (nx < 0 || ny < 0 || nx >= 64 || ny >= 64) break;
      cx = nx;
      cy = ny;
    end
    r.hit_x = cx[5:0];
    r.hit_y = cy[5:0];
  endfunction

  task automatic send_item(input ray_item_t it);
    wall_hit_t r;
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= it.func;
    s_axis_tdata <= {7'd0, it.new_frame, it.dir_y, it.dir_x, it.pos_y, it.pos_x,
                     it.tile_type, it.tile_y, it.tile_x};
    do @(posedge clk_i); while (!s_axis_tready);
    if (it.func == FuncWrite) begin
      tiles[{it.tile_y, it.tile_x}] = it.tile_type;
      writes_sent++;
    end else begin
      trace_ray(it, r);
      pending_hits.push_back(r);
      casts_sent++;
    end
  endtask

  task automatic send_write(input int x, input int y, input int t);
    ray_item_t it;
    it = '{func: FuncWrite, tile_x: 6'(x), tile_y: 6'(y), tile_type: 4'(t),
           pos_x: 16'($urandom), pos_y: 16'($urandom), dir_x: 16'($urandom),
           dir_y: 16'($urandom), new_frame: 1'($urandom)};
    send_item(it);
  endtask

  task automatic send_cast(input logic [15:0] px, input logic [15:0] py,
                           input logic [15:0] dx, input logic [15:0] dy, input bit nf);
    ray_item_t it;
    it = '{func: FuncCast, tile_x: 6'($urandom), tile_y: 6'($urandom),
           tile_type: 4'($urandom), pos_x: px, pos_y: py, dir_x: dx, dir_y: dy,
           new_frame: nf};
    send_item(it);
  endtask

  // only between phases: wait for every result, then let the block settle
  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    s_axis_tvalid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (20) @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CfgWalkableMask) walk_mask = val;
    else dist_cap = val[6:0];
  endtask

  function automatic logic [15:0] rand_dir();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'sd16384;
    if (r == 2) return -16'sd16384;
    return 16'($urandom_range(0, 32768) - 16384);
  endfunction

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      wall_hit_t got, want;
      got = '{hit: m_axis_tdata[0], hit_x: m_axis_tdata[6:1], hit_y: m_axis_tdata[12:7],
              hit_type: m_axis_tdata[16:13], first: m_axis_tdata[17]};
      results_seen++;
      if (got.hit) hits_seen++;
      if (pending_hits.size() == 0) begin
        $display("%0t: result with none expected: %h", $time, m_axis_tdata);
        errors++;
      end else begin
        want = pending_hits.pop_front();
        if (got.hit !== want.hit) begin
          $display("%0t: hit exp %0d got %0d", $time, want.hit, got.hit);
          errors++;
        end
        if (got.hit_x !== want.hit_x) begin
          $display("%0t: hit_x exp %0d got %0d", $time, want.hit_x, got.hit_x);
          errors++;
        end
        if (got.hit_y !== want.hit_y) begin
          $display("%0t: hit_y exp %0d got %0d", $time, want.hit_y, got.hit_y);
          errors++;
        end
        if (got.hit_type !== want.hit_type) begin
          $display("%0t: hit_type exp %0d got %0d", $time, want.hit_type, got.hit_type);
          errors++;
        end
        if (got.first !== want.first) begin
          $display("%0t: first_in_frame exp %0d got %0d", $time, want.first, got.first);
          errors++;
        end
      end
    end
  end

  // receiver back-pressure in short bursts
  int stall_left = 0;
  always @(posedge clk_i) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      m_axis_tready <= 1'b0;
    end else if (!no_idle && $urandom_range(0, 4) == 0) begin
      stall_left <= $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WdLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // random casts start in the lower 16x16 corner; a fence of type 15 (never walkable)
  // at row and column 16 keeps every walk on written cells
  task automatic test_fill_map();
    for (int y = 0; y <= FenceAt; y++)
      for (int x = 0; x <= FenceAt; x++)
        if (x == FenceAt || y == FenceAt)
          send_write(x, y, 15);
        else
          send_write(x, y, ($urandom_range(0, 5) == 0) ? $urandom_range(1, 14) : 0);
  endtask

  task automatic test_directed();
    send_write(0, 0, 15);
    send_write(63, 63, 0);
    send_write(0, 63, 0);
    send_write(63, 0, 0);
    send_write(3, 0, 0);
    send_cast(16'd0, 16'd0, 16'd0, 16'd0, 1'b1);         // blocking start, no motion
    send_cast(16'd0, 16'd0, 16'd0, 16'd0, 1'b0);         // same cell, already marked
    send_cast(16'hFFFF, 16'hFFFF, 16'd0, 16'd0, 1'b0);   // zero direction, open tile
    send_cast(16'hFFFF, 16'hFFFF, 16'sd16384, 16'd0, 1'b0);  // leaves the grid
    send_cast(16'hFFFF, 16'hFFFF, 16'd0, 16'sd16384, 1'b0);
    send_cast(16'h0200, 16'hFC00, -16'sd16384, 16'd0, 1'b0);
    send_cast(16'h0E00, 16'h0200, 16'd0, -16'sd16384, 1'b0);
    send_cast(16'h2200, 16'h2200, 16'sd11585, 16'sd11585, 1'b0);  // diagonal, ties
    send_cast(16'h2000, 16'h2000, -16'sd1, 16'sd1, 1'b0);
    send_cast(16'h0721, 16'h1234, 16'sd3, -16'sd16000, 1'b1);
  endtask

  task automatic test_register_extremes();
    write_reg(CfgMaxDistance, 16'd1);
    send_cast(16'h2000, 16'h2000, 16'sd16384, 16'sd5000, 1'b0);
    send_cast(16'h21FF, 16'h23FF, -16'sd7, 16'sd16384, 1'b0);
    write_reg(CfgMaxDistance, 16'd64);
    write_reg(CfgWalkableMask, 16'h7FFF);    // only type 15 blocks
    send_cast(16'h0000, 16'h2000, 16'sd16384, 16'sd1, 1'b0);
    send_cast(16'h3FFF, 16'h0000, -16'sd16384, 16'sd9000, 1'b0);
    write_reg(CfgWalkableMask, 16'h0000);    // everything blocks
    send_cast(16'h1000, 16'h2000, 16'sd100, 16'sd100, 1'b0);
    send_cast(16'h1000, 16'h2000, 16'sd100, 16'sd100, 1'b0);
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      if (p == phases - 1) no_idle = 1'b1;
      write_reg(CfgWalkableMask, 16'h0001 | 16'($urandom_range(0, 65535) & 16'h5555) |
                ($urandom_range(0, 1) ? 16'h0 : 16'h00FE));
      write_reg(CfgMaxDistance, 16'($urandom_range(0, 3) == 0 ? 64 : $urandom_range(1, 64)));
      for (int i = 0; i < per_phase; i++) begin
        if ($urandom_range(0, 2) == 0)
          send_write($urandom_range(0, FenceAt - 1), $urandom_range(0, FenceAt - 1),
                     $urandom_range(0, 3) == 0 ? $urandom_range(1, 15) : 0);
        else
          send_cast(16'($urandom_range(0, 16'h3FFF)), 16'($urandom_range(0, 16'h3FFF)),
                    rand_dir(), rand_dir(), $urandom_range(0, 39) == 0);
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_fill_map();
    test_directed();
    test_register_extremes();
    test_random(5, 265);
    s_axis_tvalid <= 1'b0;
    wait (pending_hits.size() == 0);
    repeat (600) @(posedge clk_i);
    $display("Covered %0d tile writes and %0d ray casts (%0d hits, %0d results).",
             writes_sent, casts_sent, hits_seen, results_seen);
    $display("Register settings included mask passing all but the fence, all-block, "
             + "and distance 1 and 64.");
    if (errors == 0 && pending_hits.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hw/rtl/gwf_pkg.sv
hw/rtl/grid_ray_wall_finder.sv
verif/tb_grid_ray_wall_finder.sv
